@@ rtl/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg: shared types, constants and fixed-point helpers of the ray caster
// Q16.16 saturating arithmetic, payload structs and the command/status
// structs that join the cast controller and the datapath.
// ----------------------------------------------------------------------------
package grc_pkg;

	// Map geometry and walk limit
	localparam int MapRows  = 32;
	localparam int MapCols  = 32;
	localparam int MaxSteps = 64;
	localparam int MapCells = MapRows * MapCols;
	localparam int AddrW    = $clog2(MapCells);
	localparam int StepW    = $clog2(MaxSteps + 1);
	// map coordinate: 15 integer bits of the position plus the walk excursion
	localparam int CoordW   = 17 + $clog2(MaxSteps + 1);

	// Q16.16 constants
	localparam logic signed [31:0] FxOne = 32'sh0001_0000;
	localparam logic signed [31:0] FxMax = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] FxMin = 32'sh8000_0000;

	// Shading constants
	localparam logic [8:0] ShadeHi   = 9'd180;
	localparam logic [8:0] ShadeMid  = 9'd150;
	localparam logic [8:0] ShadeLow  = 9'd120;
	localparam logic [7:0] ChanDim   = 8'd40;
	localparam logic [7:0] ChanDimG  = 8'd41;
	localparam logic [7:0] SideDrop  = 8'd20;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_POS_X       = 3'd0,
		REG_POS_Y       = 3'd1,
		REG_DIR_X       = 3'd2,
		REG_DIR_Y       = 3'd3,
		REG_PLANE_X     = 3'd4,
		REG_PLANE_Y     = 3'd5,
		REG_VIEW_WIDTH  = 3'd6,
		REG_VIEW_HEIGHT = 3'd7
	} cfg_reg_t;

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST  = 1'b1;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_INVW,
		OP_CAMX,
		OP_RDX,
		OP_RDY,
		OP_DDX,
		OP_DDY,
		OP_SDX,
		OP_SDY,
		OP_STEP,
		OP_CHECK,
		OP_LH,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic start;   // launch the arithmetic unit for op
		logic latch;   // capture the unit result for op
		logic accept;  // input transfer this cycle
	} cmd_t;

	typedef struct packed {
		logic done;       // arithmetic unit finished
		logic hit;        // cell just read is a wall
		logic step_last;  // step budget used up
		logic out_free;   // output register can take a result
	} status_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] column;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [2:0] cell_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] wall_distance;
		logic [6:0]         line_height;
		logic [6:0]         draw_start;
		logic [7:0]         draw_end;
		logic               hit_side;
		logic [2:0]         hit_cell;
		logic [15:0]        wall_color;
		logic               no_hit;
	} out_item_t;

	// Saturating add
	function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? FxMin : FxMax;
		end
		return s[31:0];
	endfunction

	// Saturating subtract
	function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic [32:0] s;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? FxMin : FxMax;
		end
		return s[31:0];
	endfunction

	// Saturating absolute value
	function automatic logic signed [31:0] fx_abs(input logic signed [31:0] a);
		if (a == FxMin) begin
			return FxMax;
		end
		return a[31] ? -a : a;
	endfunction

	// Apply a sign to a magnitude and saturate to 32 bits
	function automatic logic signed [31:0] fx_sat_mag(input logic neg,
			input logic [48:0] mag);
		if (neg) begin
			return (mag > 49'h0_8000_0000) ? FxMin : -mag[31:0];
		end
		return (mag > 49'h0_7FFF_FFFF) ? FxMax : mag[31:0];
	endfunction

endpackage

@@ rtl/grc_mul.sv @@
// ----------------------------------------------------------------------------
// grc_mul: two-stage Q16.16 multiplier
// Stage 1 forms the full product, stage 2 rounds half away from zero and
// saturates. done pulses with the result.
// ----------------------------------------------------------------------------
module grc_mul (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        a,
	input  logic signed [31:0]        b,
	output logic                      done,
	output logic signed [31:0]        result
);
	import grc_pkg::*;

	logic signed [63:0] prod_s1;
	logic               vld_s1;
	logic               vld_s2;
	logic signed [31:0] res_s2;
	logic [63:0]        mag;
	logic [47:0]        rnd;

	// Valid flags of the product and rounding stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= a * b;
		end
		if (vld_s1) begin
			res_s2 <= fx_sat_mag(prod_s1[63], {1'b0, rnd});
		end
	end

	// Round the magnitude to a Q16.16 step
	always_comb begin
		mag = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
		rnd = 48'((mag + 64'd32768) >> 16);
	end

	assign done   = vld_s2;
	assign result = res_s2;

endmodule

@@ rtl/grc_div.sv @@
// ----------------------------------------------------------------------------
// grc_div: iterative Q16.16 divider
// Restoring division, one quotient bit per cycle over the 49-bit rounded
// dividend, then sign and saturation. Division by zero returns the largest
// or smallest value by the sign of the dividend.
// ----------------------------------------------------------------------------
module grc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [31:0]        a,
	input  logic signed [31:0]        b,
	output logic                      done,
	output logic signed [31:0]        result
);
	import grc_pkg::*;

	localparam int NumW = 49;
	localparam int CntW = $clog2(NumW);

	logic            busy_q;
	logic            fin_q;
	logic [CntW-1:0] cnt_q;
	logic [NumW-1:0] num_q;
	logic [NumW-1:0] quo_q;
	logic [31:0]     rem_q;
	logic [31:0]     md_q;
	logic            neg_q;
	logic            zero_q;
	logic            aneg_q;

	logic [31:0]     mn;
	logic [31:0]     md;
	logic [32:0]     shifted;
	logic [33:0]     diff;
	logic            ge;

	always_comb begin
		mn      = a[31] ? 32'(-a) : 32'(a);
		md      = b[31] ? 32'(-b) : 32'(b);
		shifted = {rem_q, num_q[NumW-1]};
		diff    = {1'b0, shifted} - {2'b00, md_q};
		ge      = !diff[33];
	end

	// Control: run the bit loop, then pulse fin_q to finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= (b != 32'sd0);
				fin_q  <= (b == 32'sd0);
				cnt_q  <= CntW'(NumW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// Datapath of the bit loop
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= {1'b0, mn, 16'd0} + {18'd0, md[31:1]};
			md_q   <= md;
			rem_q  <= '0;
			quo_q  <= '0;
			neg_q  <= a[31] != b[31];
			zero_q <= (b == 32'sd0);
			aneg_q <= a[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : shifted[31:0];
			quo_q <= {quo_q[NumW-2:0], ge};
			num_q <= {num_q[NumW-2:0], 1'b0};
		end
	end

	assign done   = fin_q;
	assign result = zero_q ? (aneg_q ? FxMin : FxMax) : fx_sat_mag(neg_q, quo_q);

endmodule

@@ rtl/grc_dp.sv @@
// ----------------------------------------------------------------------------
// grc_dp: ray caster datapath
// Configuration registers, map memory, ray setup registers, DDA walk state,
// the shared multiplier and divider, shading and the output register.
// ----------------------------------------------------------------------------
module grc_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  grc_pkg::cmd_t        cmd,
	output grc_pkg::status_t     status,
	input  grc_pkg::in_item_t    in_data,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output grc_pkg::out_item_t   out_data
);
	import grc_pkg::*;

	// Configuration
	logic [30:0]        pos_x_q, pos_y_q;
	logic signed [31:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [7:0]         view_width_q;
	logic [6:0]         view_height_q;

	// Ray setup and walk state
	logic [7:0]               col_q;
	logic signed [31:0]       invw_q, camx_q, rdx_q, rdy_q, ddx_q, ddy_q;
	logic signed [31:0]       sdx_q, sdy_q, lhq_q;
	logic signed [CoordW-1:0] mx_q, my_q;
	logic [StepW-1:0]         n_q;
	logic                     side_q;
	logic                     inrange_q;
	logic                     hit_q;
	logic [2:0]               cell_q;

	// Map memory
	logic [2:0]       mem [MapCells];
	logic [2:0]       rd_q;
	logic [AddrW-1:0] rd_addr;

	// Output register
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res;

	// Unit ports
	logic               is_div;
	logic signed [31:0] mul_a, mul_b, div_a, div_b, mul_res, div_res;
	logic               mul_done, div_done;

	logic signed [31:0] pos_xs, pos_ys, mx_fp, my_fp, distx, disty, perp;
	logic signed [CoordW-1:0] mx_nxt, my_nxt;
	logic               step_x, nxt_in;
	logic [14:0]        lh_raw;
	logic [6:0]         lh;
	logic [5:0]         h_half, lh_half;
	logic [6:0]         ds;
	logic [7:0]         r, g, b;

	function automatic logic [7:0] sat255(input logic [8:0] v);
		return v[8] ? 8'd255 : v[7:0];
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q       <= 31'd589824;
			pos_y_q       <= 31'd720896;
			dir_x_q       <= 32'sd0;
			dir_y_q       <= -32'sd65536;
			plane_x_q     <= 32'sd43253;
			plane_y_q     <= 32'sd0;
			view_width_q  <= 8'd120;
			view_height_q <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_POS_X:       pos_x_q       <= cfg_data[30:0];
				REG_POS_Y:       pos_y_q       <= cfg_data[30:0];
				REG_DIR_X:       dir_x_q       <= cfg_data;
				REG_DIR_Y:       dir_y_q       <= cfg_data;
				REG_PLANE_X:     plane_x_q     <= cfg_data;
				REG_PLANE_Y:     plane_y_q     <= cfg_data;
				REG_VIEW_WIDTH:  view_width_q  <= cfg_data[7:0];
				REG_VIEW_HEIGHT: view_height_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Derived position terms and the next DDA cell
	always_comb begin
		pos_xs = {1'b0, pos_x_q};
		pos_ys = {1'b0, pos_y_q};
		mx_fp  = {1'b0, pos_x_q[30:16], 16'd0};
		my_fp  = {1'b0, pos_y_q[30:16], 16'd0};
		distx  = rdx_q[31] ? fx_sub(pos_xs, mx_fp) : fx_sub(fx_add(mx_fp, FxOne), pos_xs);
		disty  = rdy_q[31] ? fx_sub(pos_ys, my_fp) : fx_sub(fx_add(my_fp, FxOne), pos_ys);
		step_x = sdx_q < sdy_q;
		mx_nxt = mx_q;
		my_nxt = my_q;
		if (step_x) begin
			mx_nxt = rdx_q[31] ? mx_q - 1'b1 : mx_q + 1'b1;
		end else begin
			my_nxt = rdy_q[31] ? my_q - 1'b1 : my_q + 1'b1;
		end
		nxt_in = (mx_nxt >= 0) && (mx_nxt < CoordW'(MapRows))
			&& (my_nxt >= 0) && (my_nxt < CoordW'(MapCols));
		rd_addr = AddrW'(mx_nxt) * AddrW'(MapCols) + AddrW'(my_nxt);
		perp = side_q ? fx_sub(sdy_q, ddy_q) : fx_sub(sdx_q, ddx_q);
	end

	// Operand selection for the shared units
	always_comb begin
		is_div = cmd.op inside {OP_INVW, OP_DDX, OP_DDY, OP_LH};
		mul_a  = plane_x_q;
		mul_b  = camx_q;
		div_a  = FxOne;
		div_b  = {8'd0, view_width_q, 16'd0};
		case (cmd.op)
			OP_CAMX: begin
				mul_a = {7'd0, col_q, 1'b0, 16'd0};
				mul_b = invw_q;
			end
			OP_RDY: mul_a = plane_y_q;
			OP_SDX: begin
				mul_a = distx;
				mul_b = ddx_q;
			end
			OP_SDY: begin
				mul_a = disty;
				mul_b = ddy_q;
			end
			OP_DDX: div_b = rdx_q;
			OP_DDY: div_b = rdy_q;
			OP_LH: begin
				div_a = {9'd0, view_height_q, 16'd0};
				div_b = perp;
			end
			default: ;
		endcase
	end

	grc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && !is_div),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start && is_div),
		.a      (div_a),
		.b      (div_b),
		.done   (div_done),
		.result (div_res)
	);

	// Map memory: write on a cell transfer, read the next cell during a step
	always_ff @(posedge clk) begin
		if (cmd.accept && in_data.kind == KIND_WRITE
				&& 32'(in_data.cell_x) < MapRows && 32'(in_data.cell_y) < MapCols) begin
			mem[AddrW'(in_data.cell_x) * AddrW'(MapCols) + AddrW'(in_data.cell_y)]
				<= in_data.cell_value;
		end
		if (cmd.op == OP_STEP) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Ray setup, walk and result capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q <= in_data.column;
			mx_q  <= CoordW'(pos_x_q[30:16]);
			my_q  <= CoordW'(pos_y_q[30:16]);
			n_q   <= '0;
			hit_q <= 1'b0;
		end
		if (cmd.latch) begin
			case (cmd.op)
				OP_INVW: invw_q <= div_res;
				OP_CAMX: camx_q <= fx_sub(mul_res, FxOne);
				OP_RDX:  rdx_q  <= fx_add(mul_res, dir_x_q);
				OP_RDY:  rdy_q  <= fx_add(mul_res, dir_y_q);
				OP_DDX:  ddx_q  <= fx_abs(div_res);
				OP_DDY:  ddy_q  <= fx_abs(div_res);
				OP_SDX:  sdx_q  <= mul_res;
				OP_SDY:  sdy_q  <= mul_res;
				OP_LH:   lhq_q  <= div_res;
				default: ;
			endcase
		end
		// advance one cell
		if (cmd.op == OP_STEP) begin
			if (step_x) begin
				sdx_q <= fx_add(sdx_q, ddx_q);
			end else begin
				sdy_q <= fx_add(sdy_q, ddy_q);
			end
			mx_q      <= mx_nxt;
			my_q      <= my_nxt;
			side_q    <= !step_x;
			inrange_q <= nxt_in;
			n_q       <= n_q + 1'b1;
		end
		if (cmd.op == OP_CHECK) begin
			hit_q  <= status.hit;
			cell_q <= rd_q;
		end
	end

	// Line height, rows and shading
	always_comb begin
		lh_raw  = lhq_q[31] ? 15'd0 : lhq_q[30:16];
		lh      = (lh_raw > 15'(view_height_q)) ? view_height_q : lh_raw[6:0];
		h_half  = view_height_q[6:1];
		lh_half = lh[6:1];
		ds      = (h_half >= lh_half) ? 7'(h_half - lh_half) : 7'd0;
		case (cell_q)
			3'd1: begin
				r = sat255(ShadeMid + 9'(lh));
				g = ChanDim;
				b = ChanDim;
			end
			3'd2: begin
				r = ChanDimG;
				g = sat255(ShadeMid + 9'(lh));
				b = ChanDimG;
			end
			3'd3: begin
				r = ChanDim;
				g = sat255(ShadeLow + 9'(lh));
				b = sat255(ShadeMid + 9'(lh));
			end
			3'd5: begin
				r = sat255(ShadeHi + 9'(lh));
				g = r;
				b = ChanDim;
			end
			default: begin
				r = sat255(ShadeHi + 9'(lh));
				g = r;
				b = r;
			end
		endcase
		// darken the y side
		if (side_q) begin
			r = r - SideDrop;
			g = g - SideDrop;
			b = b - SideDrop;
		end
		res = '0;
		if (hit_q) begin
			res.wall_distance = perp;
			res.line_height   = lh;
			res.draw_start    = ds;
			res.draw_end      = 8'(ds) + 8'(lh);
			res.hit_side      = side_q;
			res.hit_cell      = cell_q;
			res.wall_color    = {b[7:3], g[7:3], 1'b0, r[7:3]};
		end else begin
			res.no_hit = 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT && status.out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT && status.out_free) begin
			out_q <= res;
		end
	end

	assign status.done      = mul_done || div_done;
	assign status.hit       = inrange_q && (rd_q != 3'd0);
	assign status.step_last = (n_q == StepW'(MaxSteps));
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/grc_ctrl.sv @@
// ----------------------------------------------------------------------------
// grc_ctrl: cast sequencer
// Steps one cast through ray setup, the DDA walk, the height division on a
// hit and the output transfer; one unit operation in flight at a time.
// ----------------------------------------------------------------------------
module grc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_ready,
	input  grc_pkg::status_t  status,
	output grc_pkg::cmd_t     cmd
);
	import grc_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_INVW  = 13'b0000000000010,
		S_CAMX  = 13'b0000000000100,
		S_RDX   = 13'b0000000001000,
		S_RDY   = 13'b0000000010000,
		S_DDX   = 13'b0000000100000,
		S_DDY   = 13'b0000001000000,
		S_SDX   = 13'b0000010000000,
		S_SDY   = 13'b0000100000000,
		S_STEP  = 13'b0001000000000,
		S_CHECK = 13'b0010000000000,
		S_LH    = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   pend_q;
	logic   unit_state;

	always_comb begin
		state_d    = state_q;
		cmd.op     = OP_NONE;
		cmd.accept = 1'b0;
		unit_state = 1'b1;
		in_ready   = 1'b0;
		case (state_q)
			S_IDLE: begin
				unit_state = 1'b0;
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && in_kind == KIND_CAST) begin
					state_d = S_INVW;
				end
			end
			S_INVW: begin
				cmd.op = OP_INVW;
				if (pend_q && status.done) state_d = S_CAMX;
			end
			S_CAMX: begin
				cmd.op = OP_CAMX;
				if (pend_q && status.done) state_d = S_RDX;
			end
			S_RDX: begin
				cmd.op = OP_RDX;
				if (pend_q && status.done) state_d = S_RDY;
			end
			S_RDY: begin
				cmd.op = OP_RDY;
				if (pend_q && status.done) state_d = S_DDX;
			end
			S_DDX: begin
				cmd.op = OP_DDX;
				if (pend_q && status.done) state_d = S_DDY;
			end
			S_DDY: begin
				cmd.op = OP_DDY;
				if (pend_q && status.done) state_d = S_SDX;
			end
			S_SDX: begin
				cmd.op = OP_SDX;
				if (pend_q && status.done) state_d = S_SDY;
			end
			S_SDY: begin
				cmd.op = OP_SDY;
				if (pend_q && status.done) state_d = S_STEP;
			end
			S_STEP: begin
				unit_state = 1'b0;
				cmd.op     = OP_STEP;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				unit_state = 1'b0;
				cmd.op     = OP_CHECK;
				if (status.hit) begin
					state_d = S_LH;
				end else if (status.step_last) begin
					state_d = S_OUT;
				end else begin
					state_d = S_STEP;
				end
			end
			S_LH: begin
				cmd.op = OP_LH;
				if (pend_q && status.done) state_d = S_OUT;
			end
			S_OUT: begin
				unit_state = 1'b0;
				cmd.op     = OP_OUT;
				if (status.out_free) state_d = S_IDLE;
			end
			default: begin
				unit_state = 1'b0;
				state_d    = S_IDLE;
			end
		endcase
		cmd.start = unit_state && !pend_q;
		cmd.latch = unit_state && pend_q && status.done;
	end

	// Hold the state and whether a unit operation is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				pend_q <= 1'b1;
			end else if (cmd.latch) begin
				pend_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/grid_ray_caster_column_top.sv @@
// ----------------------------------------------------------------------------
// grid_ray_caster_column_top: column ray caster over a 3-bit cell grid
//
//   channel | signals                                  | direction
//   in      | in_valid, in_ready, in_data (in_item_t)  | item in
//   out     | out_valid, out_ready, out_data           | result out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| register write
//
// A cell write is taken while idle and leaves the caster idle. A cast that
// meets a wall runs four divisions on the shared bit-serial divider and five
// products on the shared multiplier, one at a time, walks the grid with a
// step state and a check state per grid step, and ends in the output state.
// A cast that runs out of 64 steps skips the height division.
// Reset clears the controller, unit control and output valid, and loads the
// register defaults; the map is undefined until written. A stalled output
// holds the finished cast back while in_ready stays low.
// ----------------------------------------------------------------------------
module grid_ray_caster_column_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  grc_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output grc_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import grc_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (in_data.kind),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	grc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
